[sv/blue_pixel_window_counter_unit_defines.svh]
`ifndef BLUE_PIXEL_WINDOW_COUNTER_UNIT_DEFINES_SVH
`define BLUE_PIXEL_WINDOW_COUNTER_UNIT_DEFINES_SVH

// property checked on every rising edge, skipped while reset is held
`define BPWC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define BPWC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/bpwc_pkg.sv]
`timescale 1ns / 1ps

package bpwc_pkg;

  localparam int PIX_W      = 8;
  localparam int COUNT_W    = 21;
  localparam int SIZE_W     = 11;
  localparam int MARGIN_W   = 10;
  localparam int CFG_W      = 21;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [COUNT_W-1:0] TALLY_MAX = {COUNT_W{1'b1}};

  // blue wins when blue * BLUE_GAIN > max(green, red) * OTHER_GAIN (ratio 1.8)
  localparam int BLUE_GAIN  = 5;
  localparam int OTHER_GAIN = 9;

  localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH    = SIZE_W'(320);
  localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT   = SIZE_W'(240);
  localparam logic [SIZE_W-1:0]   RST_BAND_FIRST_ROW = SIZE_W'(96);
  localparam logic [SIZE_W-1:0]   RST_BAND_END_ROW   = SIZE_W'(144);
  localparam logic [MARGIN_W-1:0] RST_COLUMN_MARGIN  = MARGIN_W'(30);
  localparam logic [COUNT_W-1:0]  RST_NEAR_LIMIT     = COUNT_W'(8000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_BAND_FIRST_ROW = 3'd2,
    REG_BAND_END_ROW   = 3'd3,
    REG_COLUMN_MARGIN  = 3'd4,
    REG_NEAR_LIMIT     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic [SIZE_W-1:0]   band_first_row;
    logic [SIZE_W-1:0]   band_end_row;
    logic [MARGIN_W-1:0] column_margin;
    logic [COUNT_W-1:0]  near_limit;
  } cfg_t;

  // first member in the highest bits, so blue lands in the low byte
  typedef struct packed {
    logic [PIX_W-1:0] red_level;
    logic [PIX_W-1:0] green_level;
    logic [PIX_W-1:0] blue_level;
  } pix_t;

  typedef struct packed {
    logic               marble_collected;
    logic               marble_near;
    logic [COUNT_W-1:0] total_count;
    logic [COUNT_W-1:0] right_count;
    logic [COUNT_W-1:0] left_count;
  } res_t;

  localparam int IN_BITS     = $bits(pix_t);
  localparam int RES_BITS    = $bits(res_t);
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

endpackage

[sv/blue_pixel_window_counter_unit.sv]
`timescale 1ns / 1ps

// Counts strongly blue pixels (blue above 1.8 times the larger of green and red)
// inside a row band and between column margins of a raster BGR stream, split into
// left and right halves, and emits one summary item on the last pixel of every
// frame. A pixel is taken every cycle unless the input stalls: each accepted
// pixel is held in the input register, and when it leaves that register the
// position counters and tallies update from it while a frame-ending pixel loads
// its summary into the output register and raises the output valid.
// The input stalls only when a frame ends while the previous summary is still
// waiting to be taken.
// There are no results between frame ends; frame geometry is set through the
// write port and takes effect once the write is registered.
module blue_pixel_window_counter_unit #(
  parameter int MAX_WIDTH  = bpwc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpwc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // blue_level, green_level, red_level
  input  logic [bpwc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // left_count, right_count, total_count, marble_near, marble_collected, zero pad
  output logic [bpwc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [bpwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpwc_pkg::CFG_W-1:0]       cfg_wdata
);
  import bpwc_pkg::*;

  cfg_t cfg;
  pix_t pix_r;
  logic in_valid_r, in_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t res_r;
  res_t res;
  logic is_blue;
  logic frame_last;
  logic out_free;
  logic fire;
  logic in_acc;

  bpwc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpwc_pixel_test u_test (
    .pix     (pix_r),
    .is_blue (is_blue)
  );

  bpwc_frame_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fire       (fire),
    .is_blue    (is_blue),
    .frame_last (frame_last),
    .res        (res)
  );

  // only a frame-ending item needs room in the output register
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && (!frame_last || out_free);
  assign in_tready = !in_valid_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire && frame_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= in_tdata[IN_BITS-1:0];
    end
    if (fire && frame_last) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_BITS){1'b0}}, res_r};

endmodule

[sv/bpwc_cfg_regs.sv]
`timescale 1ns / 1ps

module bpwc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bpwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpwc_pkg::CFG_W-1:0]     cfg_wdata,
  output bpwc_pkg::cfg_t                 cfg
);
  import bpwc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    cfg_nxt.frame_width    = cfg_wdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   cfg_nxt.frame_height   = cfg_wdata[SIZE_W-1:0];
        REG_BAND_FIRST_ROW: cfg_nxt.band_first_row = cfg_wdata[SIZE_W-1:0];
        REG_BAND_END_ROW:   cfg_nxt.band_end_row   = cfg_wdata[SIZE_W-1:0];
        REG_COLUMN_MARGIN:  cfg_nxt.column_margin  = cfg_wdata[MARGIN_W-1:0];
        REG_NEAR_LIMIT:     cfg_nxt.near_limit     = cfg_wdata[COUNT_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= RST_FRAME_WIDTH;
      cfg_r.frame_height   <= RST_FRAME_HEIGHT;
      cfg_r.band_first_row <= RST_BAND_FIRST_ROW;
      cfg_r.band_end_row   <= RST_BAND_END_ROW;
      cfg_r.column_margin  <= RST_COLUMN_MARGIN;
      cfg_r.near_limit     <= RST_NEAR_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/bpwc_pixel_test.sv]
`timescale 1ns / 1ps

module bpwc_pixel_test (
  input  bpwc_pkg::pix_t pix,
  output logic           is_blue
);
  import bpwc_pkg::*;

  localparam int PROD_W = PIX_W + 4;

  logic [PIX_W-1:0]  other_max;
  logic [PROD_W-1:0] blue_scaled;
  logic [PROD_W-1:0] other_scaled;

  assign other_max    = (pix.green_level > pix.red_level) ? pix.green_level : pix.red_level;
  assign blue_scaled  = PROD_W'(pix.blue_level) * PROD_W'(BLUE_GAIN);
  assign other_scaled = PROD_W'(other_max) * PROD_W'(OTHER_GAIN);
  assign is_blue      = blue_scaled > other_scaled;

endmodule

[sv/bpwc_frame_track.sv]
`timescale 1ns / 1ps

module bpwc_frame_track #(
  parameter int MAX_WIDTH  = bpwc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpwc_pkg::DEF_MAX_HEIGHT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bpwc_pkg::cfg_t cfg,
  input  logic           fire,
  input  logic           is_blue,
  output logic           frame_last,
  output bpwc_pkg::res_t res
);
  import bpwc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int BIG = (CW > RW) ? CW : RW;
  localparam int XW  = ((BIG > SIZE_W) ? BIG : SIZE_W) + 2;

  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic [COUNT_W-1:0] right_r, right_nxt;
  logic               prev_near_r, prev_near_nxt;

  logic [XW-1:0]      w_x, h_x;
  logic [XW-1:0]      col_x, row_x;
  logic [XW-1:0]      col_inc, row_inc;
  logic               in_band, in_cols, hit, left_half;
  logic [COUNT_W-1:0] left_bump, right_bump;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] total;
  logic               near;

  // clamp the frame size into 1 .. max
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_x = XW'(1);
    end else if (XW'(cfg.frame_width) > XW'(MAX_WIDTH)) begin
      w_x = XW'(MAX_WIDTH);
    end else begin
      w_x = XW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_x = XW'(1);
    end else if (XW'(cfg.frame_height) > XW'(MAX_HEIGHT)) begin
      h_x = XW'(MAX_HEIGHT);
    end else begin
      h_x = XW'(cfg.frame_height);
    end
  end

  // position left outside a shrunk frame wraps before use
  always_comb begin
    col_x = XW'(col_r);
    row_x = XW'(row_r);
    if (col_x >= w_x) begin
      col_x = '0;
      row_x = row_x + XW'(1);
    end
    if (row_x >= h_x) begin
      row_x = '0;
    end
  end

  assign col_inc    = col_x + XW'(1);
  assign row_inc    = row_x + XW'(1);
  assign frame_last = (col_inc == w_x) && (row_inc == h_x);

  assign in_band   = (row_x >= XW'(cfg.band_first_row)) && (row_x < XW'(cfg.band_end_row));
  assign in_cols   = (col_x >= XW'(cfg.column_margin)) &&
                     ((col_x + XW'(cfg.column_margin)) < w_x);
  assign left_half = {col_x[XW-2:0], 1'b0} < w_x;
  assign hit       = in_band && in_cols && is_blue;

  assign left_bump  = (hit && left_half && (left_r != TALLY_MAX)) ? left_r + 1'b1 : left_r;
  assign right_bump = (hit && !left_half && (right_r != TALLY_MAX)) ? right_r + 1'b1 : right_r;

  assign sum   = {1'b0, left_bump} + {1'b0, right_bump};
  assign total = sum[COUNT_W] ? TALLY_MAX : sum[COUNT_W-1:0];
  assign near  = total > cfg.near_limit;

  always_comb begin
    res.left_count       = left_bump;
    res.right_count      = right_bump;
    res.total_count      = total;
    res.marble_near      = near;
    res.marble_collected = prev_near_r && !near;
  end

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    prev_near_nxt = prev_near_r;
    if (fire) begin
      if (frame_last) begin
        col_nxt       = '0;
        row_nxt       = '0;
        left_nxt      = '0;
        right_nxt     = '0;
        prev_near_nxt = near;
      end else begin
        left_nxt  = left_bump;
        right_nxt = right_bump;
        if (col_inc >= w_x) begin
          col_nxt = '0;
          row_nxt = (row_inc >= h_x) ? '0 : row_inc[RW-1:0];
        end else begin
          col_nxt = col_inc[CW-1:0];
          row_nxt = row_x[RW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      right_r     <= '0;
      prev_near_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      prev_near_r <= prev_near_nxt;
    end
  end

endmodule

[sv/bpwc_checker.sv]
`timescale 1ns / 1ps
`include "blue_pixel_window_counter_unit_defines.svh"

module bpwc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bpwc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bpwc_pkg::*;

  res_t             res;
  logic [COUNT_W:0] sum;
  logic [COUNT_W-1:0] sat_total;

  assign res       = out_tdata[RES_BITS-1:0];
  assign sum       = {1'b0, res.left_count} + {1'b0, res.right_count};
  assign sat_total = sum[COUNT_W] ? TALLY_MAX : sum[COUNT_W-1:0];

  `BPWC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled summary changed")
  `BPWC_ASSERT(a_total_sum, clk, rst_n, out_tvalid |-> res.total_count == sat_total, "total is not the sum of the halves")
  `BPWC_ASSERT(a_near_collect, clk, rst_n, out_tvalid |-> !(res.marble_near && res.marble_collected), "collected flagged while near")
  `BPWC_ASSERT(a_in_stall, clk, rst_n, in_tvalid && !in_tready |-> out_tvalid && !out_tready, "input stalled without a waiting summary")
  `BPWC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "summary valid after reset")

endmodule

bind blue_pixel_window_counter_unit bpwc_checker u_bpwc_checker (.*);
